### src/iir_direct_form_filter_defines.svh
// Assertion macros shared by the IIR filter RTL.
// No dependencies; the including module must provide clk and arst_n.
`ifndef IIR_DIRECT_FORM_FILTER_DEFINES_SVH
`define IIR_DIRECT_FORM_FILTER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IIRDF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IIRDF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/iirdf_pkg.sv
// Shared constants, types and codes for the IIR direct-form filter.
// No dependencies; used by every module of the block.
`default_nettype none

package iirdf_pkg;

	// Block dimensions
	localparam int Channels    = 8;
	localparam int HistDepth   = 2;   // 1 or 2
	localparam int SampleBits  = 24;
	localparam int ChanBits    = 3;
	localparam int CoefBits    = 32;
	localparam int CoefFrac    = 28;
	localparam int OrderBits   = 2;
	localparam int RegIdxBits  = 3;

	localparam int ChanIdxBits = (Channels > 1) ? $clog2(Channels) : 1;
	localparam int RowBits     = HistDepth * SampleBits;

	// Stream payload widths, padded to whole bytes
	localparam int InDataBits  = ((ChanBits + 3 * SampleBits + 7) / 8) * 8;
	localparam int OutDataBits = ((ChanBits + SampleBits + 7) / 8) * 8;

	// Arithmetic sizing
	localparam int MacTerms    = 5;
	localparam int StepBits    = $clog2(MacTerms);
	localparam int AccBits     = CoefBits + SampleBits + 3;       // five exact terms
	localparam int HalfBits    = 32;                              // partial product split
	localparam int MulOpBits   = HalfBits + 1;
	localparam int ProdBits    = 2 * MulOpBits;
	localparam int ProdKeep    = 64;
	localparam int SumBits     = AccBits + 1;
	localparam int RoundShift  = 2 * CoefFrac - HalfBits;
	localparam int QBits       = SumBits + 1 - RoundShift;

	localparam logic [CoefBits-1:0] CoefOne = CoefBits'(64'd1 << CoefFrac);

	typedef enum logic [RegIdxBits-1:0] {
		REG_COEFF_B0,
		REG_COEFF_B1,
		REG_COEFF_B2,
		REG_COEFF_A1,
		REG_COEFF_A2,
		REG_INV_A0,
		REG_ORDER
	} reg_idx_t;

	typedef enum logic [0:0] {
		KIND_SAMPLE,
		KIND_PRESET
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRESET,
		ST_MAC,
		ST_ACC,
		ST_ABS,
		ST_SC_LO,
		ST_SC_HI,
		ST_SUM,
		ST_ROUND,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		MUL_B0_U,
		MUL_B1_U1,
		MUL_A1_Y1,
		MUL_B2_U2,
		MUL_A2_Y2,
		MUL_MAG_LO,
		MUL_MAG_HI
	} mul_sel_t;

	typedef struct packed {
		logic signed [CoefBits-1:0] b0;
		logic signed [CoefBits-1:0] b1;
		logic signed [CoefBits-1:0] b2;
		logic signed [CoefBits-1:0] a1;
		logic signed [CoefBits-1:0] a2;
		logic signed [CoefBits-1:0] inv_a0;
	} coef_set_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		logic     acc_clr;
		logic     acc_add;
		logic     abs_en;
		logic     lo_save;
		logic     sum_en;
		logic     round_en;
	} dp_ctrl_t;

	typedef struct packed {
		dp_ctrl_t dp;
		logic     ready;
		logic     hist_wr;
		logic     emit;
	} seq_ctl_t;

endpackage

`default_nettype wire

### src/iirdf_hist_store.sv
// Per-channel input and output history memories, one row per channel.
// Depends on iirdf_pkg. Rows never written read as zero via valid bits.
`default_nettype none

module iirdf_hist_store (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd_en,
	input  logic [iirdf_pkg::ChanIdxBits-1:0] rd_addr,
	input  logic                              wr_en,
	input  logic [iirdf_pkg::ChanIdxBits-1:0] wr_addr,
	input  logic [iirdf_pkg::RowBits-1:0]     wr_in_row,
	input  logic [iirdf_pkg::RowBits-1:0]     wr_out_row,
	output logic [iirdf_pkg::RowBits-1:0]     rd_in_row,
	output logic [iirdf_pkg::RowBits-1:0]     rd_out_row
);

	logic [iirdf_pkg::RowBits-1:0] in_hist_mem  [iirdf_pkg::Channels];
	logic [iirdf_pkg::RowBits-1:0] out_hist_mem [iirdf_pkg::Channels];
	logic [iirdf_pkg::Channels-1:0] valid_q;

	logic [iirdf_pkg::RowBits-1:0] in_rd_q;
	logic [iirdf_pkg::RowBits-1:0] out_rd_q;
	logic                          vld_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			in_hist_mem[wr_addr]  <= wr_in_row;
			out_hist_mem[wr_addr] <= wr_out_row;
		end
		if (rd_en) begin
			in_rd_q  <= in_hist_mem[rd_addr];
			out_rd_q <= out_hist_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_rd_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_in_row  = vld_rd_q ? in_rd_q  : '0;
	assign rd_out_row = vld_rd_q ? out_rd_q : '0;

endmodule

`default_nettype wire

### src/iirdf_datapath.sv
// Shared multiplier, accumulator and 1/a0 scaling with round and clip.
// Depends on iirdf_pkg; sequenced by iirdf_seq through dp_ctrl_t.
`default_nettype none

module iirdf_datapath (
	input  logic                                    clk,
	input  iirdf_pkg::coef_set_t                    coef,
	input  logic                                    order2,
	input  logic signed [iirdf_pkg::SampleBits-1:0] sample,
	input  logic [iirdf_pkg::RowBits-1:0]           in_row,
	input  logic [iirdf_pkg::RowBits-1:0]           out_row,
	input  iirdf_pkg::dp_ctrl_t                     ctrl,
	output logic signed [iirdf_pkg::SampleBits-1:0] res,
	output logic                                    sat
);

	localparam int S  = iirdf_pkg::SampleBits;
	localparam int MB = iirdf_pkg::MulOpBits;
	localparam int AB = iirdf_pkg::AccBits;
	localparam int HB = iirdf_pkg::HalfBits;
	localparam int SB = iirdf_pkg::SumBits;
	localparam int QB = iirdf_pkg::QBits;

	localparam logic [SB:0]   RoundHalf = (SB + 1)'(1) << (iirdf_pkg::RoundShift - 1);
	localparam logic [QB-1:0] HiLimQ    = QB'((64'd1 << (S - 1)) - 64'd1);
	localparam logic [QB-1:0] NegLimQ   = QB'(64'd1 << (S - 1));
	localparam logic [S-1:0]  SatHi     = {1'b0, {(S - 1){1'b1}}};
	localparam logic [S-1:0]  SatLo     = {1'b1, {(S - 1){1'b0}}};

	logic signed [S-1:0] u1, u2, y1, y2;
	logic signed [MB-1:0] a_op, b_op;
	logic signed [iirdf_pkg::ProdBits-1:0] prod_full;
	logic signed [iirdf_pkg::ProdKeep-1:0] prod_s1;
	logic                                  sub_s1;
	logic signed [AB-1:0] acc_q;
	logic signed [AB-1:0] term;
	logic [AB-1:0]        mag_q;
	logic [iirdf_pkg::CoefBits-1:0] imag_q;
	logic                 neg_q;
	logic [iirdf_pkg::ProdKeep-HB-1:0] plo_q;
	logic [SB-1:0]        t_q;
	logic [SB:0]          qsum;
	logic [QB-1:0]        q;
	logic [S-1:0]         res_next;
	logic                 sat_next;
	logic signed [S-1:0]  res_q;
	logic                 sat_q;

	// Entry 0 is the newest value of a row
	assign u1 = in_row[0 +: S];
	assign u2 = in_row[(iirdf_pkg::HistDepth - 1) * S +: S];
	assign y1 = out_row[0 +: S];
	assign y2 = out_row[(iirdf_pkg::HistDepth - 1) * S +: S];

	always_comb begin
		a_op = '0;
		b_op = '0;
		case (ctrl.mul_sel)
			iirdf_pkg::MUL_B0_U: begin
				a_op = MB'($signed(coef.b0));
				b_op = MB'(sample);
			end
			iirdf_pkg::MUL_B1_U1: begin
				a_op = MB'($signed(coef.b1));
				b_op = MB'(u1);
			end
			iirdf_pkg::MUL_A1_Y1: begin
				a_op = MB'($signed(coef.a1));
				b_op = MB'(y1);
			end
			iirdf_pkg::MUL_B2_U2: begin
				a_op = order2 ? MB'($signed(coef.b2)) : '0;
				b_op = MB'(u2);
			end
			iirdf_pkg::MUL_A2_Y2: begin
				a_op = order2 ? MB'($signed(coef.a2)) : '0;
				b_op = MB'(y2);
			end
			iirdf_pkg::MUL_MAG_LO: begin
				a_op = MB'(mag_q[HB-1:0]);
				b_op = MB'(imag_q);
			end
			iirdf_pkg::MUL_MAG_HI: begin
				a_op = MB'(mag_q[AB-1:HB]);
				b_op = MB'(imag_q);
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	assign prod_full = a_op * b_op;
	assign term      = AB'(prod_s1);

	// Round half away from zero on the magnitude, then clip
	assign qsum = {1'b0, t_q} + RoundHalf;
	assign q    = qsum[SB:iirdf_pkg::RoundShift];

	always_comb begin
		if (neg_q) begin
			sat_next = (q > NegLimQ);
			res_next = sat_next ? SatLo : S'(-q[S-1:0]);
		end else begin
			sat_next = (q > HiLimQ);
			res_next = sat_next ? SatHi : q[S-1:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_full[iirdf_pkg::ProdKeep-1:0];
		sub_s1  <= (ctrl.mul_sel == iirdf_pkg::MUL_A1_Y1) ||
		           (ctrl.mul_sel == iirdf_pkg::MUL_A2_Y2);
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_add) begin
			acc_q <= sub_s1 ? (acc_q - term) : (acc_q + term);
		end
		if (ctrl.abs_en) begin
			mag_q  <= acc_q[AB-1] ? AB'(-acc_q) : AB'(acc_q);
			imag_q <= coef.inv_a0[iirdf_pkg::CoefBits-1] ? -coef.inv_a0 : coef.inv_a0;
			neg_q  <= acc_q[AB-1] ^ coef.inv_a0[iirdf_pkg::CoefBits-1];
		end
		if (ctrl.lo_save) begin
			plo_q <= prod_s1[iirdf_pkg::ProdKeep-1:HB];
		end
		if (ctrl.sum_en) begin
			t_q <= SB'(plo_q) + prod_s1[SB-1:0];
		end
		if (ctrl.round_en) begin
			res_q <= res_next;
			sat_q <= sat_next;
		end
	end

	assign res = res_q;
	assign sat = sat_q;

endmodule

`default_nettype wire

### src/iirdf_seq.sv
// Item sequencer: steps the shared multiplier and history write-back.
// Depends on iirdf_pkg; drives iirdf_datapath and iirdf_hist_store.
`default_nettype none

module iirdf_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  iirdf_pkg::kind_t      item_kind,
	input  logic                  chan_ok,
	input  logic                  out_free,
	output iirdf_pkg::seq_ctl_t   ctl
);

	iirdf_pkg::state_t state_q, state_next;
	logic [iirdf_pkg::StepBits-1:0] step_q;
	logic last_step;

	assign last_step = (step_q == iirdf_pkg::StepBits'(iirdf_pkg::MacTerms - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iirdf_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == iirdf_pkg::ST_MAC) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			iirdf_pkg::ST_IDLE: begin
				if (accept && chan_ok) begin
					state_next = (item_kind == iirdf_pkg::KIND_PRESET) ?
					             iirdf_pkg::ST_PRESET : iirdf_pkg::ST_MAC;
				end
			end
			iirdf_pkg::ST_PRESET: state_next = iirdf_pkg::ST_IDLE;
			iirdf_pkg::ST_MAC: begin
				if (last_step) begin
					state_next = iirdf_pkg::ST_ACC;
				end
			end
			iirdf_pkg::ST_ACC:   state_next = iirdf_pkg::ST_ABS;
			iirdf_pkg::ST_ABS:   state_next = iirdf_pkg::ST_SC_LO;
			iirdf_pkg::ST_SC_LO: state_next = iirdf_pkg::ST_SC_HI;
			iirdf_pkg::ST_SC_HI: state_next = iirdf_pkg::ST_SUM;
			iirdf_pkg::ST_SUM:   state_next = iirdf_pkg::ST_ROUND;
			iirdf_pkg::ST_ROUND: state_next = iirdf_pkg::ST_EMIT;
			iirdf_pkg::ST_EMIT: begin
				if (out_free) begin
					state_next = iirdf_pkg::ST_IDLE;
				end
			end
			default: state_next = iirdf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl            = '0;
		ctl.dp.mul_sel = iirdf_pkg::MUL_B0_U;
		unique case (state_q)
			iirdf_pkg::ST_IDLE:   ctl.ready = 1'b1;
			iirdf_pkg::ST_PRESET: ctl.hist_wr = 1'b1;
			iirdf_pkg::ST_MAC: begin
				case (step_q)
					3'd0:    ctl.dp.mul_sel = iirdf_pkg::MUL_B0_U;
					3'd1:    ctl.dp.mul_sel = iirdf_pkg::MUL_B1_U1;
					3'd2:    ctl.dp.mul_sel = iirdf_pkg::MUL_A1_Y1;
					3'd3:    ctl.dp.mul_sel = iirdf_pkg::MUL_B2_U2;
					default: ctl.dp.mul_sel = iirdf_pkg::MUL_A2_Y2;
				endcase
				ctl.dp.acc_clr = (step_q == '0);
				ctl.dp.acc_add = (step_q != '0);
			end
			iirdf_pkg::ST_ACC:   ctl.dp.acc_add = 1'b1;
			iirdf_pkg::ST_ABS:   ctl.dp.abs_en  = 1'b1;
			iirdf_pkg::ST_SC_LO: ctl.dp.mul_sel = iirdf_pkg::MUL_MAG_LO;
			iirdf_pkg::ST_SC_HI: begin
				ctl.dp.mul_sel = iirdf_pkg::MUL_MAG_HI;
				ctl.dp.lo_save = 1'b1;
			end
			iirdf_pkg::ST_SUM:   ctl.dp.sum_en   = 1'b1;
			iirdf_pkg::ST_ROUND: ctl.dp.round_en = 1'b1;
			iirdf_pkg::ST_EMIT: begin
				ctl.hist_wr = out_free;
				ctl.emit    = out_free;
			end
			default: ctl.ready = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

### src/iir_direct_form_filter.sv
// Top level of the multichannel direct-form-I IIR filter.
// Depends on iirdf_pkg, iirdf_hist_store, iirdf_datapath, iirdf_seq and the defines header.
`default_nettype none

// Eight-channel direct-form-I filter of order one or two, one item at a time. A sample
// transfer passes the MAC, ACC, ABS, SC_LO, SC_HI, SUM and ROUND states and has its result
// loaded into the output register in EMIT; no new item is accepted until the block is idle
// again. One shared 33x33 multiplier forms the five filter products (b0*u, b1*u1, a1*y1,
// b2*u2, a2*y2) in turn into a 59-bit accumulator, then two partial products of
// |acc| * |1/a0|, followed by a sum, a round (halves away from zero) and a clip to 24 bits.
// A preset transfer is accepted, then writes the history row, and emits nothing. An item
// for an absent channel is dropped in its accept cycle. The history of each channel lives
// in two synchronous memories, one row of two entries per channel; the row is read as the
// item is accepted and written back when the result is loaded, so consecutive items never
// overlap on a row. Rows never written read as zero through per-row valid bits cleared by
// reset; there is no clearing pass. The output register lets the next item be accepted
// while a result waits; an item only stalls in its final cycle if the previous result has
// still not been taken. Coefficients and order are written through the configuration port;
// the user must write them only while the block is idle; the block does not enforce this.

`include "iir_direct_form_filter_defines.svh"

module iir_direct_form_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write port
	input  logic                                  cfg_we,
	input  logic [iirdf_pkg::RegIdxBits-1:0]      cfg_addr,
	input  logic [iirdf_pkg::CoefBits-1:0]        cfg_wdata,
	// Input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [2:0] channel, [26:3] sample_value, [50:27] preset_output, [74:51] preset_input
	input  logic [iirdf_pkg::InDataBits-1:0]      s_tdata,
	// [0] kind
	input  logic                                  s_tuser,
	// Output stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [2:0] out_channel, [26:3] filtered_value
	output logic [iirdf_pkg::OutDataBits-1:0]     m_tdata,
	// [0] saturated
	output logic                                  m_tuser
);

	localparam int S  = iirdf_pkg::SampleBits;
	localparam int CB = iirdf_pkg::ChanBits;

	localparam logic [S-1:0] SatHi = {1'b0, {(S - 1){1'b1}}};
	localparam logic [S-1:0] SatLo = {1'b1, {(S - 1){1'b0}}};

	// Configuration registers
	iirdf_pkg::coef_set_t coef_q;
	logic [iirdf_pkg::OrderBits-1:0] order_q;
	logic order2;

	// Input field split
	logic [CB-1:0]       s_channel;
	logic signed [S-1:0] s_sample;
	logic signed [S-1:0] s_preset_out;
	logic signed [S-1:0] s_preset_in;
	logic                s_accept;
	logic                chan_ok;

	// Item held for the duration of its processing
	logic [CB-1:0]       chan_q;
	iirdf_pkg::kind_t    kind_q;
	logic signed [S-1:0] sample_q;
	logic signed [S-1:0] preset_out_q;
	logic signed [S-1:0] preset_in_q;

	// History memory and datapath wiring
	logic [iirdf_pkg::RowBits-1:0] rd_in_row, rd_out_row;
	logic [iirdf_pkg::RowBits-1:0] wr_in_row, wr_out_row;
	logic signed [S-1:0] res;
	logic                sat;
	iirdf_pkg::seq_ctl_t ctl;
	logic                out_free;

	// Output register
	logic                m_tvalid_q;
	logic [CB-1:0]       m_chan_q;
	logic [S-1:0]        m_value_q;
	logic                m_sat_q;

	assign s_channel    = s_tdata[CB-1:0];
	assign s_sample     = s_tdata[CB +: S];
	assign s_preset_out = s_tdata[CB + S +: S];
	assign s_preset_in  = s_tdata[CB + 2 * S +: S];

	assign s_tready = ctl.ready;
	assign s_accept = s_tvalid && s_tready;
	assign chan_ok  = (32'(s_channel) < 32'(iirdf_pkg::Channels));

	// Order 0 behaves as 1, order 3 as 2; limited by the history depth
	assign order2 = order_q[1] && (iirdf_pkg::HistDepth >= 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0     <= iirdf_pkg::CoefOne;
			coef_q.b1     <= '0;
			coef_q.b2     <= '0;
			coef_q.a1     <= '0;
			coef_q.a2     <= '0;
			coef_q.inv_a0 <= iirdf_pkg::CoefOne;
			order_q       <= iirdf_pkg::OrderBits'(2);
		end else if (cfg_we) begin
			unique case (iirdf_pkg::reg_idx_t'(cfg_addr))
				iirdf_pkg::REG_COEFF_B0: coef_q.b0     <= cfg_wdata;
				iirdf_pkg::REG_COEFF_B1: coef_q.b1     <= cfg_wdata;
				iirdf_pkg::REG_COEFF_B2: coef_q.b2     <= cfg_wdata;
				iirdf_pkg::REG_COEFF_A1: coef_q.a1     <= cfg_wdata;
				iirdf_pkg::REG_COEFF_A2: coef_q.a2     <= cfg_wdata;
				iirdf_pkg::REG_INV_A0:   coef_q.inv_a0 <= cfg_wdata;
				iirdf_pkg::REG_ORDER:    order_q       <= cfg_wdata[iirdf_pkg::OrderBits-1:0];
				default:                 order_q       <= order_q;
			endcase
		end
	end

	// Capture the item on its transfer
	always_ff @(posedge clk) begin
		if (s_accept) begin
			chan_q       <= s_channel;
			kind_q       <= iirdf_pkg::kind_t'(s_tuser);
			sample_q     <= s_sample;
			preset_out_q <= s_preset_out;
			preset_in_q  <= s_preset_in;
		end
	end

	// For a sample, the new value enters entry 0 and older entries move up one place; a preset fills every entry
	always_comb begin
		if (kind_q == iirdf_pkg::KIND_PRESET) begin
			wr_in_row  = {iirdf_pkg::HistDepth{preset_in_q}};
			wr_out_row = {iirdf_pkg::HistDepth{preset_out_q}};
		end else begin
			wr_in_row  = iirdf_pkg::RowBits'({rd_in_row, sample_q});
			wr_out_row = iirdf_pkg::RowBits'({rd_out_row, res});
		end
	end

	iirdf_hist_store u_hist (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (s_accept && chan_ok),
		.rd_addr    (iirdf_pkg::ChanIdxBits'(s_channel)),
		.wr_en      (ctl.hist_wr),
		.wr_addr    (iirdf_pkg::ChanIdxBits'(chan_q)),
		.wr_in_row  (wr_in_row),
		.wr_out_row (wr_out_row),
		.rd_in_row  (rd_in_row),
		.rd_out_row (rd_out_row)
	);

	iirdf_datapath u_dp (
		.clk     (clk),
		.coef    (coef_q),
		.order2  (order2),
		.sample  (sample_q),
		.in_row  (rd_in_row),
		.out_row (rd_out_row),
		.ctrl    (ctl.dp),
		.res     (res),
		.sat     (sat)
	);

	assign out_free = !m_tvalid_q || m_tready;

	iirdf_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (s_accept),
		.item_kind (iirdf_pkg::kind_t'(s_tuser)),
		.chan_ok   (chan_ok),
		.out_free  (out_free),
		.ctl       (ctl)
	);

	// Output register: a new result is loaded only once the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			m_chan_q  <= chan_q;
			m_value_q <= res;
			m_sat_q   <= sat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = iirdf_pkg::OutDataBits'({m_value_q, m_chan_q});
	assign m_tuser  = m_sat_q;

	`IIRDF_ASSERT_NOW(a_wr_while_busy, ctl.hist_wr, !s_tready, "history written while accepting")
	`IIRDF_ASSERT_NOW(a_emit_slot_free, ctl.emit, out_free, "result overwrote an untaken result")
	`IIRDF_ASSERT_NEXT(a_busy_after_item, s_accept && chan_ok, !s_tready, "item overlap on history")
	`IIRDF_ASSERT_NOW(a_sat_at_limit, m_tvalid_q && m_sat_q, (m_value_q == SatHi) || (m_value_q == SatLo), "clip flag without limit value")

endmodule

`default_nettype wire
